// ===== rtl/core/aarm_pkg.sv =====
// Package with the types, constants and helper functions of the axis-angle rotation block.
`timescale 1ns / 1ps
package aarm_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int AXIS_BITS     = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int CORDIC_STAGES = 16;

    localparam int OUT_BITS  = OUT_FRAC_BITS + 2;
    localparam int FRAC      = 30;
    localparam int ANG_SHIFT = 33 - ANGLE_BITS;
    localparam int MAG_BITS  = 32;
    localparam int SUM_BITS  = 2 * MAG_BITS;
    localparam int ROOT_BITS = SUM_BITS / 2;
    localparam int REM_BITS  = ROOT_BITS + 2;
    localparam int QUO_BITS  = FRAC + 1;
    localparam int UNIT_BITS = QUO_BITS + 1;
    localparam int CW        = 34;
    localparam int PW        = CW + UNIT_BITS;
    localparam int EW        = CW + 2;
    localparam int OUT_SHIFT = FRAC - OUT_FRAC_BITS;

    localparam logic signed [CW-1:0] ONE_Q30     = CW'(64'sd1 << FRAC);
    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_INV    = 34'sd652032874;

    localparam logic signed [EW:0] ROUND_HALF =
        (OUT_SHIFT > 0) ? (EW+1)'(64'sd1 << (OUT_SHIFT - 1)) : '0;
    localparam logic signed [EW:0] SAT_LIM = (EW+1)'(64'sd1 << OUT_FRAC_BITS);
    localparam logic signed [OUT_BITS-1:0] ONE_OUT = OUT_BITS'(64'sd1 << OUT_FRAC_BITS);

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] angle;
        logic signed [AXIS_BITS-1:0]  axis_x;
        logic signed [AXIS_BITS-1:0]  axis_y;
        logic signed [AXIS_BITS-1:0]  axis_z;
    } t_in;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] m00;
        logic signed [OUT_BITS-1:0] m01;
        logic signed [OUT_BITS-1:0] m02;
        logic signed [OUT_BITS-1:0] m10;
        logic signed [OUT_BITS-1:0] m11;
        logic signed [OUT_BITS-1:0] m12;
        logic signed [OUT_BITS-1:0] m20;
        logic signed [OUT_BITS-1:0] m21;
        logic signed [OUT_BITS-1:0] m22;
        logic                       zero_axis;
    } t_out;

    typedef struct packed {
        logic [2:0] sgn;
        logic       zero;
    } t_side;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 neg;
    } t_cordic;

    typedef struct packed {
        logic signed [CW-1:0] t;
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] s;
    } t_cs;

    typedef struct packed {
        logic [SUM_BITS-1:0]       op;
        logic [REM_BITS-1:0]       rem;
        logic [ROOT_BITS-1:0]      root;
        logic [2:0][MAG_BITS-1:0]  mag;
        t_side                     side;
    } t_sqrt;

    typedef struct packed {
        logic [ROOT_BITS-1:0]      root;
        logic [2:0][MAG_BITS-1:0]  mag;
        logic [2:0][ROOT_BITS-1:0] rem;
        logic [2:0][QUO_BITS-1:0]  quo;
        t_side                     side;
    } t_div;

    function automatic logic signed [CW-1:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000007;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return CW'(v);
    endfunction

    // Rounds a Q30 entry to the output step and saturates it to plus or minus one.
    function automatic logic signed [OUT_BITS-1:0] emit(input logic signed [EW-1:0] e);
        logic signed [EW:0] v;
        v = (EW+1)'(e);
        v = (v + ROUND_HALF) >>> OUT_SHIFT;
        if (v > SAT_LIM) begin
            v = SAT_LIM;
        end
        if (v < -SAT_LIM) begin
            v = -SAT_LIM;
        end
        return v[OUT_BITS-1:0];
    endfunction

endpackage

// ===== rtl/core/aarm_cordic_cell.sv =====
// One CORDIC rotation stage of the sine and cosine chain.
`timescale 1ns / 1ps
module aarm_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  aarm_pkg::t_cordic i_d,
    output aarm_pkg::t_cordic o_q
);
    localparam int CW = aarm_pkg::CW;
    localparam logic signed [CW-1:0] ATAN = aarm_pkg::atan_q30(STAGE % 32);

    aarm_pkg::t_cordic r_q;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    assign dx = i_d.y >>> (STAGE % 32);
    assign dy = i_d.x >>> (STAGE % 32);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q.neg <= i_d.neg;
            if (!i_d.z[CW-1]) begin
                r_q.x <= i_d.x - dx;
                r_q.y <= i_d.y + dy;
                r_q.z <= i_d.z - ATAN;
            end else begin
                r_q.x <= i_d.x + dx;
                r_q.y <= i_d.y - dy;
                r_q.z <= i_d.z + ATAN;
            end
        end
    end

    assign o_q = r_q;
endmodule

// ===== rtl/core/aarm_sqrt_cell.sv =====
// One digit stage of the integer square root of the axis length.
`timescale 1ns / 1ps
module aarm_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  aarm_pkg::t_sqrt i_d,
    output aarm_pkg::t_sqrt o_q
);
    localparam int RB = aarm_pkg::REM_BITS;
    localparam int QB = aarm_pkg::ROOT_BITS;

    aarm_pkg::t_sqrt r_q;
    logic [RB+1:0] rem2;
    logic [RB+1:0] trial;

    // Bring down the next pair of operand bits and try the new root bit.
    assign rem2  = {i_d.rem, i_d.op[2*STEP+1 -: 2]};
    assign trial = (RB+2)'({i_d.root, 2'b01});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q.op   <= i_d.op;
            r_q.mag  <= i_d.mag;
            r_q.side <= i_d.side;
            if (rem2 >= trial) begin
                r_q.rem  <= RB'(rem2 - trial);
                r_q.root <= {i_d.root[QB-2:0], 1'b1};
            end else begin
                r_q.rem  <= RB'(rem2);
                r_q.root <= {i_d.root[QB-2:0], 1'b0};
            end
        end
    end

    assign o_q = r_q;
endmodule

// ===== rtl/core/aarm_div_cell.sv =====
// One quotient-bit stage of the three restoring dividers that scale the axis to unit length.
`timescale 1ns / 1ps
module aarm_div_cell #(
    parameter int J = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  aarm_pkg::t_div i_d,
    output aarm_pkg::t_div o_q
);
    localparam int MB = aarm_pkg::MAG_BITS;
    localparam int RB = aarm_pkg::ROOT_BITS;
    localparam int QB = aarm_pkg::QUO_BITS;
    localparam int FR = aarm_pkg::FRAC;

    aarm_pkg::t_div r_q;
    logic [MB+FR-1:0] num  [3];
    logic [RB:0]      rem2 [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            num[k]  = {i_d.mag[k], FR'(0)};
            rem2[k] = {i_d.rem[k], num[k][J]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q.root <= i_d.root;
            r_q.mag  <= i_d.mag;
            r_q.side <= i_d.side;
            for (int k = 0; k < 3; k++) begin
                if (rem2[k] >= {1'b0, i_d.root}) begin
                    r_q.rem[k] <= RB'(rem2[k] - {1'b0, i_d.root});
                    r_q.quo[k] <= {i_d.quo[k][QB-2:0], 1'b1};
                end else begin
                    r_q.rem[k] <= RB'(rem2[k]);
                    r_q.quo[k] <= {i_d.quo[k][QB-2:0], 1'b0};
                end
            end
        end
    end

    assign o_q = r_q;
endmodule

// ===== rtl/core/aarm_delay.sv =====
// Shift line that holds sine and cosine until the unit axis catches up.
`timescale 1ns / 1ps
module aarm_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];
endmodule

// ===== rtl/core/axis_angle_rotation_matrix.sv =====
// Top level: axis-angle (Rodrigues) rotation matrix pipeline.
// The path from an accepted word to its result word in the output register runs through:
// input stage, 5 normalize, square, sum, 32 root digits, 31 quotient bits, 3 matrix, output.
// Throughput is one word per cycle; the CORDIC chain runs beside the axis path.
// A full output register that is not taken stalls the pipeline only when a result reaches it.
// Synchronous active-low reset clears the valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix #(
    parameter int CORDIC_STAGES = aarm_pkg::CORDIC_STAGES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  aarm_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output aarm_pkg::t_out o_data
);
    localparam int AXIS_BITS = aarm_pkg::AXIS_BITS;
    localparam int MAG_BITS  = aarm_pkg::MAG_BITS;
    localparam int SUM_BITS  = aarm_pkg::SUM_BITS;
    localparam int ROOT_BITS = aarm_pkg::ROOT_BITS;
    localparam int QUO_BITS  = aarm_pkg::QUO_BITS;
    localparam int UNIT_BITS = aarm_pkg::UNIT_BITS;
    localparam int FRAC      = aarm_pkg::FRAC;
    localparam int CW        = aarm_pkg::CW;
    localparam int PW        = aarm_pkg::PW;
    localparam int EW        = aarm_pkg::EW;
    localparam int AXIS_LAT  = 7 + ROOT_BITS + QUO_BITS;
    localparam int CS_DELAY  = AXIS_LAT - CORDIC_STAGES - 1;
    localparam int PIPE_LEN  = AXIS_LAT + 4;

    typedef struct packed {
        logic [2:0][MAG_BITS-1:0] mag;
        logic [MAG_BITS-1:0]      mx;
        aarm_pkg::t_side          side;
    } t_nrm;

    logic                en;
    logic [PIPE_LEN-1:0] r_vld;
    logic                r_out_vld;
    aarm_pkg::t_out      r_out;

    assign en      = !r_vld[PIPE_LEN-1] || !r_out_vld || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LEN-2:0], i_valid};
        end
    end

    // Input stage: magnitudes, signs, largest magnitude and the folded angle.
    logic signed [AXIS_BITS-1:0] in_ax [3];
    logic signed [AXIS_BITS:0]   ve    [3];
    logic [MAG_BITS-1:0]         n_mag [3];
    logic [MAG_BITS-1:0]         n_mx;
    logic signed [CW-1:0]        n_ang;
    aarm_pkg::t_cordic           n_cord;
    t_nrm                        r_nrm [6];
    aarm_pkg::t_cordic           r_cord0;

    assign in_ax[0] = i_data.axis_x;
    assign in_ax[1] = i_data.axis_y;
    assign in_ax[2] = i_data.axis_z;

    always_comb begin
        n_mx = '0;
        for (int k = 0; k < 3; k++) begin
            ve[k]    = (AXIS_BITS+1)'(in_ax[k]);
            n_mag[k] = in_ax[k][AXIS_BITS-1] ? MAG_BITS'(-ve[k]) : MAG_BITS'(ve[k]);
            if (n_mag[k] > n_mx) begin
                n_mx = n_mag[k];
            end
        end
        n_ang      = CW'(i_data.angle) <<< aarm_pkg::ANG_SHIFT;
        n_cord.x   = aarm_pkg::GAIN_INV;
        n_cord.y   = '0;
        n_cord.z   = n_ang;
        n_cord.neg = 1'b0;
        if (n_ang > aarm_pkg::HALF_PI_Q30) begin
            n_cord.z   = n_ang - aarm_pkg::PI_Q30;
            n_cord.neg = 1'b1;
        end else if (n_ang < -aarm_pkg::HALF_PI_Q30) begin
            n_cord.z   = n_ang + aarm_pkg::PI_Q30;
            n_cord.neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_nrm[0].mag[k]     <= n_mag[k];
                r_nrm[0].side.sgn[k] <= in_ax[k][AXIS_BITS-1];
            end
            r_nrm[0].mx        <= n_mx;
            r_nrm[0].side.zero <= (n_mx == '0);
            r_cord0            <= n_cord;
        end
    end

    // Normalize: shift by 16, 8, 4, 2, 1 until the largest magnitude reaches 2^30.
    for (genvar g = 0; g < 5; g++) begin : g_nrm
        localparam int SH = 16 >> g;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_nrm[g+1].side <= r_nrm[g].side;
                if (r_nrm[g].mx[MAG_BITS-1 -: SH+1] == '0) begin
                    r_nrm[g+1].mx <= r_nrm[g].mx << SH;
                    for (int k = 0; k < 3; k++) begin
                        r_nrm[g+1].mag[k] <= r_nrm[g].mag[k] << SH;
                    end
                end else begin
                    r_nrm[g+1].mx  <= r_nrm[g].mx;
                    r_nrm[g+1].mag <= r_nrm[g].mag;
                end
            end
        end
    end

    // Squares, then their sum.
    logic [SUM_BITS-1:0]      r_sq [3];
    logic [2:0][MAG_BITS-1:0] r_sq_mag;
    aarm_pkg::t_side          r_sq_side;
    aarm_pkg::t_sqrt          w_sq [ROOT_BITS+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= SUM_BITS'(r_nrm[5].mag[k]) * SUM_BITS'(r_nrm[5].mag[k]);
            end
            r_sq_mag      <= r_nrm[5].mag;
            r_sq_side     <= r_nrm[5].side;
            w_sq[0].op    <= r_sq[0] + r_sq[1] + r_sq[2];
            w_sq[0].rem   <= '0;
            w_sq[0].root  <= '0;
            w_sq[0].mag   <= r_sq_mag;
            w_sq[0].side  <= r_sq_side;
        end
    end

    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_sqrt
        aarm_sqrt_cell #(
            .STEP (ROOT_BITS - 1 - g)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_sq[g]),
            .o_q   (w_sq[g+1])
        );
    end

    // Dividers: unit component = (magnitude << 30) / root.
    aarm_pkg::t_div w_dv [QUO_BITS+1];

    always_comb begin
        w_dv[0].root = w_sq[ROOT_BITS].root;
        w_dv[0].mag  = w_sq[ROOT_BITS].mag;
        w_dv[0].side = w_sq[ROOT_BITS].side;
        for (int k = 0; k < 3; k++) begin
            w_dv[0].rem[k] = ROOT_BITS'(w_sq[ROOT_BITS].mag[k][MAG_BITS-1:1]);
            w_dv[0].quo[k] = '0;
        end
    end

    for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
        aarm_div_cell #(
            .J (QUO_BITS - 1 - g)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_dv[g]),
            .o_q   (w_dv[g+1])
        );
    end

    // CORDIC chain, quadrant fix, and the delay that lines it up with the axis path.
    aarm_pkg::t_cordic w_cd [CORDIC_STAGES+1];
    aarm_pkg::t_cs     n_cs;
    aarm_pkg::t_cs     r_cs;
    aarm_pkg::t_cs     w_csd;

    assign w_cd[0] = r_cord0;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        aarm_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_cd[g]),
            .o_q   (w_cd[g+1])
        );
    end

    always_comb begin
        n_cs.c = w_cd[CORDIC_STAGES].neg ? -w_cd[CORDIC_STAGES].x : w_cd[CORDIC_STAGES].x;
        n_cs.s = w_cd[CORDIC_STAGES].neg ? -w_cd[CORDIC_STAGES].y : w_cd[CORDIC_STAGES].y;
        n_cs.t = aarm_pkg::ONE_Q30 - n_cs.c;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cs <= n_cs;
        end
    end

    aarm_delay #(
        .WIDTH ($bits(aarm_pkg::t_cs)),
        .DEPTH (CS_DELAY)
    ) u_cs_delay (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_cs),
        .o_q   (w_csd)
    );

    // Matrix stage 1: signed unit axis, cv = t*n, sv = s*n.
    logic signed [UNIT_BITS-1:0] n_unit [3];
    logic signed [PW-1:0]        prod_cv [3];
    logic signed [PW-1:0]        prod_sv [3];
    logic signed [UNIT_BITS-1:0] r_n  [3];
    logic signed [CW-1:0]        r_cv [3];
    logic signed [CW-1:0]        r_sv [3];
    logic signed [CW-1:0]        r_c1;
    logic                        r_z1;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_unit[k]  = w_dv[QUO_BITS].side.sgn[k]
                       ? -$signed({1'b0, w_dv[QUO_BITS].quo[k]})
                       : $signed({1'b0, w_dv[QUO_BITS].quo[k]});
            prod_cv[k] = PW'(w_csd.t) * PW'(n_unit[k]);
            prod_sv[k] = PW'(w_csd.s) * PW'(n_unit[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_n[k]  <= n_unit[k];
                r_cv[k] <= prod_cv[k][FRAC+CW-1:FRAC];
                r_sv[k] <= prod_sv[k][FRAC+CW-1:FRAC];
            end
            r_c1 <= w_csd.c;
            r_z1 <= w_dv[QUO_BITS].side.zero;
        end
    end

    // Matrix stage 2: outer product n_i * cv_k.
    logic signed [PW-1:0] prod_p [3][3];
    logic signed [CW-1:0] r_p  [3][3];
    logic signed [CW-1:0] r_sv2 [3];
    logic signed [CW-1:0] r_c2;
    logic                 r_z2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                prod_p[i][k] = PW'(r_n[i]) * PW'(r_cv[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_p[i][k] <= prod_p[i][k][FRAC+CW-1:FRAC];
                end
            end
            r_sv2 <= r_sv;
            r_c2  <= r_c1;
            r_z2  <= r_z1;
        end
    end

    // Matrix stage 3: add cosine on the diagonal and the cross-product terms.
    logic signed [EW-1:0] r_e [9];
    logic                 r_z3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e[0] <= EW'(r_p[0][0]) + EW'(r_c2);
            r_e[1] <= EW'(r_p[0][1]) - EW'(r_sv2[2]);
            r_e[2] <= EW'(r_p[0][2]) + EW'(r_sv2[1]);
            r_e[3] <= EW'(r_p[1][0]) + EW'(r_sv2[2]);
            r_e[4] <= EW'(r_p[1][1]) + EW'(r_c2);
            r_e[5] <= EW'(r_p[1][2]) - EW'(r_sv2[0]);
            r_e[6] <= EW'(r_p[2][0]) - EW'(r_sv2[1]);
            r_e[7] <= EW'(r_p[2][1]) + EW'(r_sv2[0]);
            r_e[8] <= EW'(r_p[2][2]) + EW'(r_c2);
            r_z3   <= r_z2;
        end
    end

    // Output register: rounding and saturation, or the identity for a zero axis.
    logic signed [aarm_pkg::OUT_BITS-1:0] n_m [9];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            if (r_z3) begin
                n_m[k] = (k % 4 == 0) ? aarm_pkg::ONE_OUT : '0;
            end else begin
                n_m[k] = aarm_pkg::emit(r_e[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || i_ready) begin
            r_out_vld <= r_vld[PIPE_LEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_ready) begin
            r_out.m00       <= n_m[0];
            r_out.m01       <= n_m[1];
            r_out.m02       <= n_m[2];
            r_out.m10       <= n_m[3];
            r_out.m11       <= n_m[4];
            r_out.m12       <= n_m[5];
            r_out.m20       <= n_m[6];
            r_out.m21       <= n_m[7];
            r_out.m22       <= n_m[8];
            r_out.zero_axis <= r_z3;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_vld[PIPE_LEN-1] && r_out_vld && !i_ready))
        else $error("pipeline stalled without a blocked result");

    a_identity : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.zero_axis) |-> (o_data.m00 == aarm_pkg::ONE_OUT
            && o_data.m11 == aarm_pkg::ONE_OUT && o_data.m22 == aarm_pkg::ONE_OUT
            && o_data.m01 == '0 && o_data.m12 == '0 && o_data.m20 == '0))
        else $error("zero axis did not give the identity matrix");

    a_no_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[PIPE_LEN-1] && r_out_vld && !i_ready) |=> (r_vld[PIPE_LEN-1] && r_out_vld))
        else $error("result lost while the output was blocked");

endmodule
